>>> hw/rtl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
package lr_pkg;

    // Default coordinate width (signed pixel coordinates)
    localparam int LR_COORD_BITS = 12;

    // Fixed field widths
    localparam int LR_COLOR_W = 16;
    localparam int LR_CFG_W   = 11;
    localparam int LR_APB_W   = 32;
    localparam int LR_ADDR_W  = 3;

    // Register reset values
    localparam logic [LR_CFG_W-1:0] LR_WIDTH_RST  = 11'd480;
    localparam logic [LR_CFG_W-1:0] LR_HEIGHT_RST = 11'd320;

    // Input beat kind, carried on s_tuser
    typedef enum logic [0:0] {
        ACT_START   = 1'b0,
        ACT_ADVANCE = 1'b1
    } action_t;

    // Register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_idx_t;

    // Clip window handed from the register file to the core
    typedef struct packed {
        logic [LR_CFG_W-1:0] width;
        logic [LR_CFG_W-1:0] height;
    } lr_screen_t;

endpackage

>>> hw/rtl/lr_cfg_regs.sv
// APB register file holding the screen clip window.
module lr_cfg_regs
    import lr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [LR_ADDR_W-1:0] paddr,
    input  logic [LR_APB_W-1:0]  pwdata,
    output logic [LR_APB_W-1:0]  prdata,
    output logic                 pready,
    output lr_screen_t           screen
);

    logic [LR_CFG_W-1:0] width_reg;
    logic [LR_CFG_W-1:0] height_reg;
    logic                wr_en;
    reg_idx_t            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[2]);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= LR_WIDTH_RST;
            height_reg <= LR_HEIGHT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SCREEN_WIDTH:  width_reg  <= pwdata[LR_CFG_W-1:0];
                REG_SCREEN_HEIGHT: height_reg <= pwdata[LR_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_SCREEN_WIDTH:  prdata = LR_APB_W'(width_reg);
            REG_SCREEN_HEIGHT: prdata = LR_APB_W'(height_reg);
            default:           prdata = '0;
        endcase
    end

    assign screen.width  = width_reg;
    assign screen.height = height_reg;

endmodule

>>> hw/rtl/lr_in_stage.sv
// Input register stage: captures one beat and holds it until the core takes it.
module lr_in_stage
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  action_t                      s_action,
    input  logic signed [COORD_BITS-1:0] s_start_x,
    input  logic signed [COORD_BITS-1:0] s_start_y,
    input  logic signed [COORD_BITS-1:0] s_end_x,
    input  logic signed [COORD_BITS-1:0] s_end_y,
    input  logic [LR_COLOR_W-1:0]        s_color,
    output logic                         q_valid,
    input  logic                         q_ready,
    output action_t                      q_action,
    output logic signed [COORD_BITS-1:0] q_start_x,
    output logic signed [COORD_BITS-1:0] q_start_y,
    output logic signed [COORD_BITS-1:0] q_end_x,
    output logic signed [COORD_BITS-1:0] q_end_y,
    output logic [LR_COLOR_W-1:0]        q_color
);

    logic                         valid_reg;
    action_t                      action_reg;
    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] end_x_reg;
    logic signed [COORD_BITS-1:0] end_y_reg;
    logic [LR_COLOR_W-1:0]        color_reg;
    logic                         load;

    // Take a new beat when empty or when the held one moves on this cycle
    assign s_ready = !valid_reg || q_ready;
    assign load    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            action_reg  <= s_action;
            start_x_reg <= s_start_x;
            start_y_reg <= s_start_y;
            end_x_reg   <= s_end_x;
            end_y_reg   <= s_end_y;
            color_reg   <= s_color;
        end
    end

    assign q_valid   = valid_reg;
    assign q_action  = action_reg;
    assign q_start_x = start_x_reg;
    assign q_start_y = start_y_reg;
    assign q_end_x   = end_x_reg;
    assign q_end_y   = end_y_reg;
    assign q_color   = color_reg;

endmodule

>>> hw/rtl/lr_core.sv
// Bresenham step logic, line state and the result register.
module lr_core
    import lr_pkg::*;
#(
    parameter int COORD_BITS = LR_COORD_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lr_screen_t                   screen,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  action_t                      in_action,
    input  logic signed [COORD_BITS-1:0] in_start_x,
    input  logic signed [COORD_BITS-1:0] in_start_y,
    input  logic signed [COORD_BITS-1:0] in_end_x,
    input  logic signed [COORD_BITS-1:0] in_end_y,
    input  logic [LR_COLOR_W-1:0]        in_color,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         res_valid,
    output logic [COORD_BITS-1:0]        res_x,
    output logic [COORD_BITS-1:0]        res_y,
    output logic [LR_COLOR_W-1:0]        res_color,
    output logic                         res_on_screen,
    output logic                         res_last
);

    localparam int CW  = COORD_BITS;
    localparam int EW  = COORD_BITS + 3;     // error term, two's complement
    localparam int CMW = COORD_BITS + LR_CFG_W;

    // Line state
    logic [CW-1:0]         cur_x_reg,  cur_x_next;
    logic [CW-1:0]         cur_y_reg,  cur_y_next;
    logic                  xneg_reg,   xneg_next;
    logic                  yneg_reg,   yneg_next;
    logic                  xmaj_reg,   xmaj_next;
    logic [CW-1:0]         major_reg,  major_next;
    logic [CW-1:0]         minor_reg,  minor_next;
    logic [EW-1:0]         err_reg,    err_next;
    logic [CW-1:0]         left_reg,   left_next;
    logic [LR_COLOR_W-1:0] color_reg,  color_next;
    logic                  active_reg, active_next;

    // Result register
    logic                  out_valid_reg;
    logic                  rv_reg,    rv_next;
    logic [CW-1:0]         rx_reg,    rx_next;
    logic [CW-1:0]         ry_reg,    ry_next;
    logic [LR_COLOR_W-1:0] rc_reg,    rc_next;
    logic                  ron_reg,   ron_next;
    logic                  rlast_reg, rlast_next;

    logic                  fire;

    // Start decode
    logic [CW:0]   diff_x, diff_y, adx, ady;
    logic [CW-1:0] dx, dy;
    logic          x_gt, y_gt, horiz, vert, st_xmaj;
    logic [CW-1:0] st_major, st_minor;

    // Advance datapath
    logic [CW-1:0] step_x, step_y;
    logic [EW-1:0] err_add, err_sub;
    logic          err_nonneg;
    logic [CW-1:0] left_dec;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    // Endpoint deltas: one subtract per axis, sign gives direction
    always_comb begin
        diff_x   = {in_end_x[CW-1], in_end_x} - {in_start_x[CW-1], in_start_x};
        diff_y   = {in_end_y[CW-1], in_end_y} - {in_start_y[CW-1], in_start_y};
        x_gt     = !diff_x[CW] && (diff_x != '0);
        y_gt     = !diff_y[CW] && (diff_y != '0);
        adx      = diff_x[CW] ? ('0 - diff_x) : diff_x;
        ady      = diff_y[CW] ? ('0 - diff_y) : diff_y;
        dx       = adx[CW-1:0];
        dy       = ady[CW-1:0];
        horiz    = (dy == '0);
        vert     = (dx == '0) && !horiz;
        st_xmaj  = dx > dy;
        st_major = st_xmaj ? dx : dy;
        st_minor = st_xmaj ? dy : dx;
    end

    // One Bresenham step from the held state
    always_comb begin
        step_x     = cur_x_reg + (xneg_reg ? {CW{1'b1}} : CW'(1));
        step_y     = cur_y_reg + (yneg_reg ? {CW{1'b1}} : CW'(1));
        err_add    = err_reg + {2'b00, minor_reg, 1'b0};
        err_nonneg = !err_add[EW-1];
        err_sub    = err_add - {2'b00, major_reg, 1'b0};
        left_dec   = left_reg - CW'(1);
    end

    // Next state and result
    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        xmaj_next   = xmaj_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        err_next    = err_reg;
        left_next   = left_reg;
        color_next  = color_reg;
        active_next = active_reg;
        rv_next     = 1'b0;
        rlast_next  = 1'b0;

        case (in_action)
            ACT_START: begin
                color_next = in_color;
                xneg_next  = !x_gt;
                yneg_next  = !y_gt;
                cur_x_next = in_start_x;
                cur_y_next = in_start_y;
                if (horiz) begin
                    // horizontal: run from the lower column
                    cur_x_next = x_gt ? in_start_x : in_end_x;
                    xneg_next  = 1'b0;
                end else if (vert) begin
                    // vertical: run from the lower row
                    cur_y_next = y_gt ? in_start_y : in_end_y;
                    yneg_next  = 1'b0;
                end
                xmaj_next   = st_xmaj;
                major_next  = st_major;
                minor_next  = st_minor;
                err_next    = EW'(0) - EW'(st_major);
                left_next   = st_major;
                active_next = (st_major != '0);
                rv_next     = 1'b1;
                rlast_next  = (st_major == '0);
            end
            ACT_ADVANCE: begin
                if (active_reg) begin
                    if (xmaj_reg) begin
                        cur_x_next = step_x;
                        if (err_nonneg) begin
                            cur_y_next = step_y;
                        end
                    end else begin
                        cur_y_next = step_y;
                        if (err_nonneg) begin
                            cur_x_next = step_x;
                        end
                    end
                    err_next    = err_nonneg ? err_sub : err_add;
                    left_next   = left_dec;
                    active_next = (left_dec != '0);
                    rv_next     = 1'b1;
                    rlast_next  = (left_dec == '0);
                end
            end
            default: ;
        endcase
    end

    // Pixel fields; all zero when an advance finds no line
    always_comb begin
        if (rv_next) begin
            rx_next  = cur_x_next;
            ry_next  = cur_y_next;
            rc_next  = color_next;
            ron_next = !cur_x_next[CW-1] && !cur_y_next[CW-1]
                    && (CMW'(cur_x_next) < CMW'(screen.width))
                    && (CMW'(cur_y_next) < CMW'(screen.height));
        end else begin
            rx_next  = '0;
            ry_next  = '0;
            rc_next  = '0;
            ron_next = 1'b0;
        end
    end

    // Line state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            xneg_reg   <= 1'b0;
            yneg_reg   <= 1'b0;
            xmaj_reg   <= 1'b0;
            major_reg  <= '0;
            minor_reg  <= '0;
            err_reg    <= '0;
            left_reg   <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
        end else if (fire) begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            xneg_reg   <= xneg_next;
            yneg_reg   <= yneg_next;
            xmaj_reg   <= xmaj_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            err_reg    <= err_next;
            left_reg   <= left_next;
            color_reg  <= color_next;
            active_reg <= active_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            rv_reg    <= rv_next;
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            rc_reg    <= rc_next;
            ron_reg   <= ron_next;
            rlast_reg <= rlast_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign res_valid     = rv_reg;
    assign res_x         = rx_reg;
    assign res_y         = ry_reg;
    assign res_color     = rc_reg;
    assign res_on_screen = ron_reg;
    assign res_last      = rlast_reg;

`ifndef SYNTHESIS
    // A line is active exactly while pixels remain
    a_active_left: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg == (left_reg != '0))
        else $error("line_active and pixel count disagree");

    // The error term stays negative between steps of an active line
    a_err_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> err_reg[EW-1])
        else $error("error term not negative while active");

    // Emitting the final pixel ends the line
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && rlast_next) |=> (!active_reg && res_last && out_valid))
        else $error("line still active after last pixel");

    // An advance with no line gives an invalid result and leaves state alone
    a_idle_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_action == ACT_ADVANCE && !active_reg)
            |=> (out_valid && !res_valid && !active_reg && $stable(cur_x_reg)))
        else $error("advance while idle misbehaved");
`endif

endmodule

>>> hw/rtl/line_rasterizer_unit.sv
// Top level of the line rasterizer: stream ports, APB registers, pipeline.
//
// Bresenham line rasterizer. A start beat (s_tuser = 0) loads both endpoints
// and the color and returns the first pixel; each advance beat (s_tuser = 1)
// returns the next pixel, and m_tlast marks the final one. An advance with no
// line in progress returns a beat with valid_res = 0 and all fields zero; a
// start while a line runs drops the old line. Every beat in gives exactly one
// beat out. Throughput is one beat per clock while m_tready is high: a
// beat passes an input register and then the step logic into the result
// register, raising m_tvalid. s_tready follows m_tready combinationally when
// both registers are full. Pixels outside the screen_width/screen_height
// window (or with negative coordinates) are still emitted with on_screen = 0.
// Registers: screen_width at byte address 0, screen_height at 4 (11 bits
// each); write them only while no line beats are in flight.
module line_rasterizer_unit
    import lr_pkg::*;
#(
    parameter  int COORD_BITS = LR_COORD_BITS,
    localparam int S_DATA_W   = ((4 * COORD_BITS + LR_COLOR_W + 7) / 8) * 8,
    localparam int M_DATA_W   = ((2 * COORD_BITS + LR_COLOR_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // APB configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [LR_ADDR_W-1:0] paddr,
    input  logic [LR_APB_W-1:0]  pwdata,
    output logic [LR_APB_W-1:0]  prdata,
    output logic                 pready,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,  // start_x, start_y, end_x, end_y, line_color
    input  logic [0:0]           s_tuser,  // action
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,  // pixel_x, pixel_y, pixel_color
    output logic [1:0]           m_tuser,  // valid_res, on_screen
    output logic                 m_tlast
);

    localparam int CW = COORD_BITS;

    lr_screen_t                   screen;
    logic                         q_valid;
    logic                         q_ready;
    action_t                      q_action;
    logic signed [CW-1:0]         q_start_x;
    logic signed [CW-1:0]         q_start_y;
    logic signed [CW-1:0]         q_end_x;
    logic signed [CW-1:0]         q_end_y;
    logic [LR_COLOR_W-1:0]        q_color;
    logic                         res_valid;
    logic [CW-1:0]                res_x;
    logic [CW-1:0]                res_y;
    logic [LR_COLOR_W-1:0]        res_color;
    logic                         res_on_screen;

    // Configuration registers
    lr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .screen  (screen)
    );

    // Input beat register
    lr_in_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_action  (action_t'(s_tuser[0])),
        .s_start_x (s_tdata[CW-1:0]),
        .s_start_y (s_tdata[2*CW-1:CW]),
        .s_end_x   (s_tdata[3*CW-1:2*CW]),
        .s_end_y   (s_tdata[4*CW-1:3*CW]),
        .s_color   (s_tdata[4*CW+LR_COLOR_W-1:4*CW]),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_action  (q_action),
        .q_start_x (q_start_x),
        .q_start_y (q_start_y),
        .q_end_x   (q_end_x),
        .q_end_y   (q_end_y),
        .q_color   (q_color)
    );

    // Step logic and result register
    lr_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .screen        (screen),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_action     (q_action),
        .in_start_x    (q_start_x),
        .in_start_y    (q_start_y),
        .in_end_x      (q_end_x),
        .in_end_y      (q_end_y),
        .in_color      (q_color),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .res_valid     (res_valid),
        .res_x         (res_x),
        .res_y         (res_y),
        .res_color     (res_color),
        .res_on_screen (res_on_screen),
        .res_last      (m_tlast)
    );

    // Pack the result beat
    assign m_tdata = M_DATA_W'({res_color, res_y, res_x});
    assign m_tuser = {res_on_screen, res_valid};

endmodule
